[sv/eop_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eop_pkg: shared types and constants for the even/odd partition block
// Default buffer depth, sequencer state codes and the step decision record.
// ----------------------------------------------------------------------------
package eop_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RDL  = 6'b000010,
		ST_RDR  = 6'b000100,
		ST_DEC  = 6'b001000,
		ST_SWP  = 6'b010000,
		ST_EMIT = 6'b100000
	} state_t;

	// outcome of one partition step
	typedef struct packed {
		logic swap;
		logic inc_left;
		logic dec_right;
		logic more;
	} step_t;

endpackage

[sv/eop_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eop_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module eop_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/eop_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eop_step: shared partition step unit
// Decide swap and pointer moves from the two parities and compare the
// moved pointers.
// ----------------------------------------------------------------------------
module eop_step #(
	parameter int AW = 6
) (
	input  logic            left_odd,
	input  logic            right_odd,
	input  logic [AW-1:0]   left,
	input  logic [AW-1:0]   right,
	output logic [AW-1:0]   left_nxt,
	output logic [AW-1:0]   right_nxt,
	output eop_pkg::step_t  step
);
	import eop_pkg::*;

	always_comb begin
		step.swap      = left_odd & ~right_odd;
		// left moves unless both sides are odd; right moves unless both are even
		step.inc_left  = ~(left_odd & right_odd);
		step.dec_right = left_odd | right_odd;
		left_nxt       = step.inc_left  ? left  + AW'(1) : left;
		right_nxt      = step.dec_right ? right - AW'(1) : right;
		step.more      = left_nxt < right_nxt;
	end

endmodule

[sv/even_odd_partition.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// even_odd_partition: load, even/odd partition and emit of a signed array
// Command-style block that buffers elements, partitions them in place with
// two closing pointers, and streams the result back out.
// ----------------------------------------------------------------------------
// Usage:
//   Present value/last with start; the request is taken at a rising edge where
//   start is high and busy is low. Each request that is not marked last
//   produces nothing. Elements past DEPTH are dropped, but a dropped
//   element marked last still closes the array.
//   After the last request busy rises and the partition runs on the stored
//   array: each step reads the left and right entries through the single read
//   port (states RDL, RDR, DEC), plus a SWP state when the step swaps, since
//   the RAM has one write port. At most N-1 steps for N elements.
//   Results then come out one per cycle, evens first, in buffer order;
//   strobe marks each for exactly one cycle and last_res marks the final
//   one. Each result follows its EMIT state through the registered RAM read.
//   The receiver cannot stall: results are never held.
//   busy drops in the cycle the final result is shown; a new array may be
//   loaded from then on.
//   Reset clears the sequencer, element count and strobe; buffer contents
//   are not cleared and are never emitted before being written.
// ----------------------------------------------------------------------------
module even_odd_partition #(
	parameter int DEPTH = eop_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [eop_pkg::VAL_W-1:0] value,
	input  logic                             last,
	output logic                             strobe,
	output logic signed [eop_pkg::VAL_W-1:0] value_res,
	output logic                             last_res
);
	import eop_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     left_q;
	logic [AW-1:0]     right_q;
	logic [AW-1:0]     idx_q;
	logic [VAL_W-1:0]  lv_q;
	logic              valid_s1;
	logic              last_s1;

	logic              accept;
	logic              room;
	logic [CW-1:0]     count_nxt;
	logic              emit_last;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [VAL_W-1:0]  wdata;
	logic [AW-1:0]     raddr;
	logic [VAL_W-1:0]  rdata;

	logic [AW-1:0]     left_nxt;
	logic [AW-1:0]     right_nxt;
	step_t             step;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start & ~busy;
	assign room      = count_q < CW'(DEPTH);
	assign count_nxt = room ? count_q + CW'(1) : count_q;
	assign emit_last = CW'(idx_q) == count_q - CW'(1);

	// shared step unit: parity decision and pointer compare
	eop_step #(
		.AW (AW)
	) u_step (
		.left_odd  (lv_q[0]),
		.right_odd (rdata[0]),
		.left      (left_q),
		.right     (right_q),
		.left_nxt  (left_nxt),
		.right_nxt (right_nxt),
		.step      (step)
	);

	// RAM port control: write for load, first half of a swap, second half of a swap; read address per state
	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = value;
		raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				we = accept & room;
			end
			ST_RDL: begin
				raddr = left_q;
			end
			ST_RDR: begin
				raddr = right_q;
			end
			ST_DEC: begin
				we    = step.swap;
				waddr = left_q;
				wdata = rdata;
			end
			ST_SWP: begin
				we    = 1'b1;
				waddr = right_q;
				wdata = lv_q;
			end
			ST_EMIT: begin
				raddr = idx_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	eop_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			left_q   <= '0;
			right_q  <= '0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= count_nxt;
						if (last) begin
							left_q  <= '0;
							right_q <= AW'(count_nxt - CW'(1));
							idx_q   <= '0;
							// a lone element needs no partition step
							state_q <= (count_nxt < CW'(2)) ? ST_EMIT : ST_RDL;
						end
					end
				end
				ST_RDL: begin
					state_q <= ST_RDR;
				end
				ST_RDR: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (step.swap) begin
						// hold pointers until the right entry is written
						state_q <= ST_SWP;
					end else begin
						left_q  <= left_nxt;
						right_q <= right_nxt;
						state_q <= step.more ? ST_RDL : ST_EMIT;
					end
				end
				ST_SWP: begin
					left_q  <= left_q + AW'(1);
					right_q <= right_q - AW'(1);
					state_q <= (left_q + AW'(1) < right_q - AW'(1)) ? ST_RDL : ST_EMIT;
				end
				ST_EMIT: begin
					valid_s1 <= 1'b1;
					last_s1  <= emit_last;
					if (emit_last) begin
						count_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// capture the left entry while the right one is being read
	always_ff @(posedge clk) begin
		if (state_q == ST_RDR) begin
			lv_q <= rdata;
		end
	end

	assign strobe    = valid_s1;
	assign value_res = rdata;
	assign last_res  = last_s1;

	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q == ST_EMIT))
		else $error("result strobe without an emit cycle");

	a_dec_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DEC) |-> (left_q < right_q))
		else $error("partition step with crossed pointers");

	a_last_marks_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_res |-> strobe)
		else $error("last_res without strobe");

	a_last_request_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last) |=> busy)
		else $error("block not busy after final request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count beyond buffer depth");

endmodule
